### design/tpd_pkg.sv
// tpd_pkg: shared constants and types of the tagged packet deframer
// phase codes, the start tag, kind and status codes and the result beat struct
// no dependencies
`default_nettype none

package tpd_pkg;

  localparam logic [7:0] START_TAG = 8'hFB;

  localparam int unsigned PHASE_W = 4;

  localparam logic [PHASE_W-1:0] PH_HUNT  = 4'd0;
  localparam logic [PHASE_W-1:0] PH_TYPE  = 4'd1;
  localparam logic [PHASE_W-1:0] PH_SEQ_H = 4'd2;
  localparam logic [PHASE_W-1:0] PH_SEQ_L = 4'd3;
  localparam logic [PHASE_W-1:0] PH_CMD_H = 4'd4;
  localparam logic [PHASE_W-1:0] PH_CMD_L = 4'd5;
  localparam logic [PHASE_W-1:0] PH_LEN_H = 4'd6;
  localparam logic [PHASE_W-1:0] PH_LEN_L = 4'd7;
  localparam logic [PHASE_W-1:0] PH_BODY  = 4'd8;
  localparam logic [PHASE_W-1:0] PH_SUM   = 4'd9;
  localparam logic [PHASE_W-1:0] PH_END   = 4'd10;

  localparam logic KIND_DATA   = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_SUM_BAD = 2'd1;
  localparam logic [1:0] ST_LEN_BIG = 2'd2;

  typedef struct packed {
    logic        item_kind;
    logic [7:0]  pkt_type;
    logic [15:0] seq_num;
    logic [15:0] command;
    logic [15:0] body_len;
    logic [7:0]  data_byte;
    logic [1:0]  status;
    logic        last;
  } result_t;

endpackage

`default_nettype wire

### design/tagged_packet_deframer.sv
// tagged_packet_deframer: frames tagged packets out of a received byte stream
// uses tpd_pkg for phase codes, status codes and the result struct
//
// usage
//   input channel: one stream byte per beat on rx_byte_i, taken at an edge
//   with in_valid_i high and in_stall_o low. bytes are dropped until the
//   0xFB start tag, then type, sequence, command and length are read big
//   endian. each body byte gives a data beat carrying the header fields;
//   after the checksum byte the next byte (end tag, value not checked)
//   gives a status beat with last set. a length above BODY_LEN_MAX ends the
//   packet at once with a length status beat and no body beats.
//   output channel: result beats leave from a register, taken at an edge
//   with out_valid_o high and out_stall_i low.
//   a result is registered at the edge that takes its byte.
//   throughput: one byte per cycle while in_stall_o is low; the phase decode,
//   checksum add and length compare all feed the result register directly.
//   stall: a skid register catches one result while the output is held;
//   in_stall_o rises only while that skid register is full, so the input
//   side never waits on a combinational path from out_stall_i.
//   reset: asynchronous, active low; returns to start-tag hunting with all
//   header fields, counters and the checksum cleared, no beats pending.
`default_nettype none

module tagged_packet_deframer #(
  parameter int unsigned BODY_LEN_MAX = 65525
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  rx_byte_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic             item_kind_o,
  output logic [7:0]       pkt_type_o,
  output logic [15:0]      seq_num_o,
  output logic [15:0]      command_o,
  output logic [15:0]      body_len_o,
  output logic [7:0]       data_byte_o,
  output logic [1:0]       status_o,
  output logic             last_o
);

  localparam logic [16:0] LenMax = 17'(BODY_LEN_MAX);

  // framing state
  logic [tpd_pkg::PHASE_W-1:0] phase_q, phase_d;
  logic [7:0]  type_q, type_d;
  logic [15:0] seq_q, seq_d;
  logic [15:0] cmd_q, cmd_d;
  logic [15:0] len_q, len_d;
  logic [15:0] cnt_q, cnt_d;
  logic [7:0]  sum_q, sum_d;
  logic        bad_q, bad_d;

  // output register and skid register
  logic             out_valid_q;
  tpd_pkg::result_t out_q;
  logic             skid_valid_q;
  tpd_pkg::result_t skid_q;

  logic             accept;
  logic             res_valid;
  tpd_pkg::result_t res;
  logic [7:0]       sum_add;
  logic             out_free;

  assign in_stall_o = skid_valid_q;
  assign accept     = in_valid_i && !skid_valid_q;
  assign out_free   = !out_valid_q || !out_stall_i;

  // running checksum step: c = 2c + byte mod 256
  assign sum_add = {sum_q[6:0], 1'b0} + rx_byte_i;

  always_comb begin
    phase_d   = phase_q;
    type_d    = type_q;
    seq_d     = seq_q;
    cmd_d     = cmd_q;
    len_d     = len_q;
    cnt_d     = cnt_q;
    sum_d     = sum_q;
    bad_d     = bad_q;
    res_valid = 1'b0;
    res       = '0;

    case (phase_q)
      tpd_pkg::PH_HUNT: begin
        if (rx_byte_i == tpd_pkg::START_TAG) begin
          // checksum restarts at the tag: 2*0 + tag
          sum_d   = rx_byte_i;
          bad_d   = 1'b0;
          cnt_d   = '0;
          phase_d = tpd_pkg::PH_TYPE;
        end
      end
      tpd_pkg::PH_TYPE: begin
        sum_d   = sum_add;
        type_d  = rx_byte_i;
        phase_d = tpd_pkg::PH_SEQ_H;
      end
      tpd_pkg::PH_SEQ_H: begin
        sum_d   = sum_add;
        seq_d   = {rx_byte_i, 8'h00};
        phase_d = tpd_pkg::PH_SEQ_L;
      end
      tpd_pkg::PH_SEQ_L: begin
        sum_d   = sum_add;
        seq_d   = {seq_q[15:8], rx_byte_i};
        phase_d = tpd_pkg::PH_CMD_H;
      end
      tpd_pkg::PH_CMD_H: begin
        sum_d   = sum_add;
        cmd_d   = {rx_byte_i, 8'h00};
        phase_d = tpd_pkg::PH_CMD_L;
      end
      tpd_pkg::PH_CMD_L: begin
        sum_d   = sum_add;
        cmd_d   = {cmd_q[15:8], rx_byte_i};
        phase_d = tpd_pkg::PH_LEN_H;
      end
      tpd_pkg::PH_LEN_H: begin
        sum_d   = sum_add;
        len_d   = {rx_byte_i, 8'h00};
        phase_d = tpd_pkg::PH_LEN_L;
      end
      tpd_pkg::PH_LEN_L: begin
        sum_d = sum_add;
        len_d = {len_q[15:8], rx_byte_i};
        cnt_d = '0;
        if ({1'b0, len_d} > LenMax) begin
          // oversize length closes the packet right away
          res_valid = 1'b1;
          res.item_kind = tpd_pkg::KIND_STATUS;
          res.status    = tpd_pkg::ST_LEN_BIG;
          res.last      = 1'b1;
          phase_d = tpd_pkg::PH_HUNT;
        end else if (len_d == 16'd0) begin
          phase_d = tpd_pkg::PH_SUM;
        end else begin
          phase_d = tpd_pkg::PH_BODY;
        end
      end
      tpd_pkg::PH_BODY: begin
        sum_d = sum_add;
        cnt_d = cnt_q + 16'd1;
        if (cnt_d >= len_q) begin
          phase_d = tpd_pkg::PH_SUM;
        end
        res_valid = 1'b1;
        res.item_kind = tpd_pkg::KIND_DATA;
        res.data_byte = rx_byte_i;
        res.status    = tpd_pkg::ST_OK;
        res.last      = 1'b0;
      end
      tpd_pkg::PH_SUM: begin
        bad_d   = (rx_byte_i != sum_q);
        phase_d = tpd_pkg::PH_END;
      end
      tpd_pkg::PH_END: begin
        // end tag value is not checked
        res_valid = 1'b1;
        res.item_kind = tpd_pkg::KIND_STATUS;
        res.status    = bad_q ? tpd_pkg::ST_SUM_BAD : tpd_pkg::ST_OK;
        res.last      = 1'b1;
        phase_d = tpd_pkg::PH_HUNT;
      end
      default: begin
        phase_d = tpd_pkg::PH_HUNT;
      end
    endcase

    // header fields as they stand after this byte
    res.pkt_type = type_d;
    res.seq_num  = seq_d;
    res.command  = cmd_d;
    res.body_len = len_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= tpd_pkg::PH_HUNT;
      type_q  <= '0;
      seq_q   <= '0;
      cmd_q   <= '0;
      len_q   <= '0;
      cnt_q   <= '0;
      sum_q   <= '0;
      bad_q   <= 1'b0;
    end else if (accept) begin
      phase_q <= phase_d;
      type_q  <= type_d;
      seq_q   <= seq_d;
      cmd_q   <= cmd_d;
      len_q   <= len_d;
      cnt_q   <= cnt_d;
      sum_q   <= sum_d;
      bad_q   <= bad_d;
    end
  end

  // output register with one skid entry
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_free) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= accept && res_valid;
      end
    end else if (accept && res_valid) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      if (skid_valid_q) begin
        out_q <= skid_q;
      end else if (accept && res_valid) begin
        out_q <= res;
      end
    end else if (accept && res_valid) begin
      skid_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign item_kind_o = out_q.item_kind;
  assign pkt_type_o  = out_q.pkt_type;
  assign seq_num_o   = out_q.seq_num;
  assign command_o   = out_q.command;
  assign body_len_o  = out_q.body_len;
  assign data_byte_o = out_q.data_byte;
  assign status_o    = out_q.status;
  assign last_o      = out_q.last;

endmodule

`default_nettype wire

### dv/tpd_checker.sv
// tpd_checker: watches both channels of the tagged packet deframer, predicts each result beat
// from the accepted stream bytes and compares them field by field
// depends on tpd_pkg for phase codes, tag and status codes and result_t
`timescale 1ns / 1ps

module tpd_checker #(
  parameter int unsigned BODY_LEN_MAX = 65525
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  input  wire logic        in_stall_i,
  input  wire logic [7:0]  rx_byte_i,
  input  wire logic        out_valid_i,
  input  wire logic        out_stall_i,
  input  wire logic        item_kind_i,
  input  wire logic [7:0]  pkt_type_i,
  input  wire logic [15:0] seq_num_i,
  input  wire logic [15:0] command_i,
  input  wire logic [15:0] body_len_i,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic [1:0]  status_i,
  input  wire logic        last_i,
  output int               fail_count_o,
  output int               pending_o,
  output int               beats_o
);

  // predicted deframer state
  logic [tpd_pkg::PHASE_W-1:0] frame_phase;
  logic [7:0]         hdr_type;
  logic [15:0]        hdr_seq;
  logic [15:0]        hdr_cmd;
  logic [15:0]        hdr_len;
  logic [15:0]        body_seen;
  logic [7:0]         chk_acc;
  logic               chk_mismatch;

  tpd_pkg::result_t expected_beats[$];

  function automatic tpd_pkg::result_t make_beat(input logic kind, input logic [7:0] data,
                                                 input logic [1:0] st);
    tpd_pkg::result_t r;
    r.item_kind = kind;
    r.pkt_type  = hdr_type;
    r.seq_num   = hdr_seq;
    r.command   = hdr_cmd;
    r.body_len  = hdr_len;
    r.data_byte = data;
    r.status    = st;
    r.last      = (kind == tpd_pkg::KIND_STATUS);
    return r;
  endfunction

  task automatic deframe_byte(input logic [7:0] b);
    // checksum covers start tag through the last body byte
    if (frame_phase != tpd_pkg::PH_HUNT && frame_phase != tpd_pkg::PH_SUM &&
        frame_phase != tpd_pkg::PH_END) begin
      chk_acc = (chk_acc << 1) + b;
    end
    case (frame_phase)
      tpd_pkg::PH_HUNT: begin
        if (b == tpd_pkg::START_TAG) begin
          chk_acc      = b;
          chk_mismatch = 1'b0;
          body_seen    = '0;
          frame_phase  = tpd_pkg::PH_TYPE;
        end
      end
      tpd_pkg::PH_TYPE: begin
        hdr_type    = b;
        frame_phase = tpd_pkg::PH_SEQ_H;
      end
      tpd_pkg::PH_SEQ_H: begin
        hdr_seq     = {b, 8'h00};
        frame_phase = tpd_pkg::PH_SEQ_L;
      end
      tpd_pkg::PH_SEQ_L: begin
        hdr_seq     = {hdr_seq[15:8], b};
        frame_phase = tpd_pkg::PH_CMD_H;
      end
      tpd_pkg::PH_CMD_H: begin
        hdr_cmd     = {b, 8'h00};
        frame_phase = tpd_pkg::PH_CMD_L;
      end
      tpd_pkg::PH_CMD_L: begin
        hdr_cmd     = {hdr_cmd[15:8], b};
        frame_phase = tpd_pkg::PH_LEN_H;
      end
      tpd_pkg::PH_LEN_H: begin
        hdr_len     = {b, 8'h00};
        frame_phase = tpd_pkg::PH_LEN_L;
      end
      tpd_pkg::PH_LEN_L: begin
        hdr_len   = {hdr_len[15:8], b};
        body_seen = '0;
        if (hdr_len > BODY_LEN_MAX) begin
          expected_beats.push_back(make_beat(tpd_pkg::KIND_STATUS, 8'h00,
                                             tpd_pkg::ST_LEN_BIG));
          frame_phase = tpd_pkg::PH_HUNT;
        end else begin
          frame_phase = (hdr_len == 16'd0) ? tpd_pkg::PH_SUM : tpd_pkg::PH_BODY;
        end
      end
      tpd_pkg::PH_BODY: begin
        body_seen = body_seen + 16'd1;
        if (body_seen >= hdr_len) frame_phase = tpd_pkg::PH_SUM;
        expected_beats.push_back(make_beat(tpd_pkg::KIND_DATA, b, tpd_pkg::ST_OK));
      end
      tpd_pkg::PH_SUM: begin
        chk_mismatch = (b != chk_acc);
        frame_phase  = tpd_pkg::PH_END;
      end
      tpd_pkg::PH_END: begin
        // end tag value is not checked
        expected_beats.push_back(make_beat(tpd_pkg::KIND_STATUS, 8'h00,
                                           chk_mismatch ? tpd_pkg::ST_SUM_BAD
                                                        : tpd_pkg::ST_OK));
        frame_phase = tpd_pkg::PH_HUNT;
      end
      default: frame_phase = tpd_pkg::PH_HUNT;
    endcase
  endtask

  task automatic compare_field(input string fname, input logic [15:0] want,
                               input logic [15:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0h, actual %0h", fname, want, got);
      fail_count_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    tpd_pkg::result_t want;
    if (!rst_ni) begin
      frame_phase  = tpd_pkg::PH_HUNT;
      hdr_type     = '0;
      hdr_seq      = '0;
      hdr_cmd      = '0;
      hdr_len      = '0;
      body_seen    = '0;
      chk_acc      = '0;
      chk_mismatch = 1'b0;
      expected_beats.delete();
      fail_count_o = 0;
      pending_o    = 0;
      beats_o      = 0;
    end else begin
      // check the outgoing beat before predicting from this edge's byte
      if (out_valid_i && !out_stall_i) begin
        beats_o++;
        if (expected_beats.size() == 0) begin
          $error("result beat with nothing expected");
          fail_count_o++;
        end else begin
          want = expected_beats.pop_front();
          compare_field("item_kind", 16'(want.item_kind), 16'(item_kind_i));
          compare_field("pkt_type",  16'(want.pkt_type),  16'(pkt_type_i));
          compare_field("seq_num",   want.seq_num,        seq_num_i);
          compare_field("command",   want.command,        command_i);
          compare_field("body_len",  want.body_len,       body_len_i);
          compare_field("data_byte", 16'(want.data_byte), 16'(data_byte_i));
          compare_field("status",    16'(want.status),    16'(status_i));
          compare_field("last",      16'(want.last),      16'(last_i));
        end
      end
      if (in_valid_i && !in_stall_i) deframe_byte(rx_byte_i);
      pending_o = expected_beats.size();
    end
  end

endmodule

### dv/tb.sv
// tb: stimulus and verdict for the tagged packet deframer
// drives framed byte streams with random gaps and output stalls; tpd_checker predicts and compares
// depends on tpd_pkg, tagged_packet_deframer and tpd_checker
`timescale 1ns / 1ps

module tb;

  localparam int unsigned LEN_LIMIT   = 65525;
  localparam logic [7:0]  END_TAG     = 8'hFE;
  localparam int          CYCLE_LIMIT = 1000000;
  localparam int          PHASE_BYTES = 135;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic [7:0]  rx_byte_i   = 8'h00;
  logic        out_stall_i = 1'b0;
  logic        in_stall_o;
  logic        out_valid_o;
  logic        item_kind_o;
  logic [7:0]  pkt_type_o;
  logic [15:0] seq_num_o;
  logic [15:0] command_o;
  logic [15:0] body_len_o;
  logic [7:0]  data_byte_o;
  logic [1:0]  status_o;
  logic        last_o;

  int fail_count;
  int pending;
  int beats;

  // idle rates in percent per cycle, changed between stimulus phases
  int send_idle_pct = 9;
  int recv_idle_pct = 68;

  int pkt_count  = 0;
  int byte_count = 0;
  int cycle_count = 0;

  // 8 ns clock
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  tagged_packet_deframer #(
    .BODY_LEN_MAX(LEN_LIMIT)
  ) u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .rx_byte_i   (rx_byte_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .item_kind_o (item_kind_o),
    .pkt_type_o  (pkt_type_o),
    .seq_num_o   (seq_num_o),
    .command_o   (command_o),
    .body_len_o  (body_len_o),
    .data_byte_o (data_byte_o),
    .status_o    (status_o),
    .last_o      (last_o)
  );

  tpd_checker #(
    .BODY_LEN_MAX(LEN_LIMIT)
  ) u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_i   (in_stall_o),
    .rx_byte_i    (rx_byte_i),
    .out_valid_i  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .item_kind_i  (item_kind_o),
    .pkt_type_i   (pkt_type_o),
    .seq_num_i    (seq_num_o),
    .command_i    (command_o),
    .body_len_i   (body_len_o),
    .data_byte_i  (data_byte_o),
    .status_i     (status_o),
    .last_i       (last_o),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .beats_o      (beats)
  );

  // receiver side: random stall, one decision per falling edge
  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < recv_idle_pct);
  end

  // watchdog on total run length
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d beats still expected", cycle_count, pending);
      $display("*** FAILED ***");
      $finish;
    end
  end

  // one stream beat; entered and left just after a falling edge
  // valid is only lowered for a gap, so it never toggles within one step
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      rx_byte_i  <= 8'($urandom);   // junk while idle must be ignored
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    rx_byte_i  <= b;
    // hold the beat until an edge takes it
    do @(posedge clk_i); while (in_stall_o);
    byte_count++;
    @(negedge clk_i);
  endtask

  // start tag, header, body, checksum and end tag; an oversize length stops after the header
  task automatic send_packet(input logic [7:0] typ, input logic [15:0] seq,
                             input logic [15:0] cmd, input logic [15:0] len,
                             input bit sum_err, input logic [7:0] tail);
    logic [7:0] hdr [8];
    logic [7:0] crc;
    logic [7:0] b;
    hdr = '{tpd_pkg::START_TAG, typ, seq[15:8], seq[7:0], cmd[15:8], cmd[7:0], len[15:8],
            len[7:0]};
    crc = 8'h00;
    pkt_count++;
    for (int i = 0; i < 8; i++) begin
      crc = (crc << 1) + hdr[i];
      send_byte(hdr[i]);
    end
    if (len > LEN_LIMIT) return;
    for (int k = 0; k < int'(len); k++) begin
      // a start tag inside the body is plain data
      b   = ($urandom_range(7) == 0) ? tpd_pkg::START_TAG : 8'($urandom);
      crc = (crc << 1) + b;
      send_byte(b);
    end
    send_byte(sum_err ? (crc ^ 8'($urandom_range(255, 1))) : crc);
    send_byte(tail);
  endtask

  initial begin
    int         phase_start;
    int         sel;
    int         noise;
    logic [15:0] len;
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: noise while hunting, extremes of the header fields,
    // empty body, oversize length, start tag as header content,
    // bad checksum and an end tag of another value
    send_byte(8'h00);
    send_byte(8'hFF);
    send_packet(8'hFF, 16'hFFFF, 16'h0000, 16'h0000, 1'b0, END_TAG);
    send_packet(8'h00, 16'h0000, 16'hFFFF, 16'hFFFF, 1'b0, END_TAG);
    send_packet(tpd_pkg::START_TAG, 16'h00FB, 16'hFB00, 16'h0001, 1'b1, 8'h00);

    // random packets under three idle mixes
    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          send_idle_pct = 9;
          recv_idle_pct = 68;
        end
        1: begin
          send_idle_pct = 68;
          recv_idle_pct = 9;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      phase_start = byte_count;
      while (byte_count - phase_start < PHASE_BYTES) begin
        // occasional junk between packets; a stray start tag misframes the next one
        noise = ($urandom_range(3) == 0) ? $urandom_range(3, 1) : 0;
        repeat (noise) send_byte(8'($urandom));
        sel = $urandom_range(99);
        if (sel < 8) len = 16'($urandom_range(16'hFFFF, LEN_LIMIT + 1));
        else if (sel < 14) len = 16'($urandom_range(300, 13));
        else len = 16'($urandom_range(12, 0));
        send_packet(8'($urandom), 16'($urandom), 16'($urandom), len,
                    ($urandom_range(5) == 0),
                    ($urandom_range(3) == 0) ? 8'($urandom) : END_TAG);
      end
    end

    // one packet just one byte over the length limit
    send_packet(8'h5A, 16'h8000, 16'hFFFF, 16'(LEN_LIMIT + 1), 1'b0, END_TAG);
    in_valid_i <= 1'b0;

    // drain, then wait quietly for any stray beat
    while (pending != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);

    $display("sent %0d packets in %0d stream bytes over three sender/receiver idle mixes",
             pkt_count, byte_count);
    $display("compared %0d result beats, oversize lengths tried just past the %0d-byte limit",
             beats, LEN_LIMIT);
    if (fail_count == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

### sim.f
design/tpd_pkg.sv
design/tagged_packet_deframer.sv
dv/tpd_checker.sv
dv/tb.sv
